FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files that carry checks.
// Each macro takes a label, a condition, a consequence and a message string.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rlbp_pkg.sv
// ----------------------------------------------------------------------------
// rlbp_pkg
// Types and constants for the remote link byte parser.
// ----------------------------------------------------------------------------
package rlbp_pkg;

    // Number of bytes in a radio command, the 'R' byte included.
    localparam int RADIO_LEN = 5;
    localparam int IDX_W     = $clog2(RADIO_LEN + 1);
    localparam int RADIO_AW  = (RADIO_LEN > 1) ? $clog2(RADIO_LEN) : 1;
    localparam int RADIO_W   = 40;

    // Bytes of the link protocol.
    localparam logic [7:0] BYTE_CONNECT = 8'h03;
    localparam logic [7:0] BYTE_PONG    = 8'h03;
    localparam logic [7:0] BYTE_ZERO    = 8'h00;
    localparam logic [7:0] BYTE_V_UP    = 8'h56;
    localparam logic [7:0] BYTE_K_UP    = 8'h4B;
    localparam logic [7:0] BYTE_R_UP    = 8'h52;
    localparam logic [7:0] PING_MAX     = 8'hFF;
    localparam logic [7:0] MAX_PINGS_RESET = 8'd4;

    // Event codes on the result channel.
    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_KEY     = 3'd1,
        EV_RADIO   = 3'd2,
        EV_PONG    = 3'd3,
        EV_CONN    = 3'd4,
        EV_DISC    = 3'd5,
        EV_UNKNOWN = 3'd6
    } event_t;

    // Command decoder state.
    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_KEY   = 4'b0010,
        MODE_RADIO = 4'b0100,
        MODE_PONG  = 4'b1000
    } mode_t;

endpackage

FILE: hw/rtl/remote_link_byte_parser_unit.sv
// ----------------------------------------------------------------------------
// remote_link_byte_parser_unit
// Decodes the byte stream of a wired remote control and supervises the link.
// ----------------------------------------------------------------------------
// Usage:
// Each input word is either a received byte (func = 0) or a keepalive tick
// (func = 1). It is taken when in_valid is high and in_stall is low.
// Every input word yields exactly one result word on the output channel,
// taken when out_valid is high and out_stall is low.
// The word passes an input register and then a result register. One word is
// taken every cycle while the receiver does not stall; the rate is set by the
// single decode pass between the two registers, which also updates the link
// state.
// When the receiver stalls, the finished result holds in the result register;
// if the input register is empty, one more input word is still taken into it;
// after that in_stall rises until the result is taken.
// The ping limit is written over the cfg channel, which is always ready.
// Reset clears the link (disconnected), the decoder, the ping count and the
// valid flags of both pipeline registers, and sets the ping limit to four.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module remote_link_byte_parser_unit
    import rlbp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // Input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                func,
    input  logic [7:0]          rx_byte,
    // Result channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          event_res,
    output logic [7:0]          key_code,
    output logic [RADIO_W-1:0]  radio_command,
    output logic [7:0]          unknown_byte,
    output logic                link_up,
    output logic                send_ping,
    output logic                clear_hold,
    // Configuration channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);

    // Pipeline control.
    logic                s1_valid_reg;
    logic                s1_func_reg;
    logic [7:0]          s1_byte_reg;
    logic                out_valid_reg;
    logic                s2_free;
    logic                s1_adv;

    // Link state.
    logic                conn_reg, conn_next;
    mode_t               mode_reg, mode_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [7:0]          pc_reg, pc_next;
    logic [7:0]          max_reg;
    logic [7:0]          rb_reg [RADIO_LEN];

    // Decode results.
    event_t              ev;
    logic [7:0]          key_val;
    logic [RADIO_W-1:0]  radio_val;
    logic [7:0]          unk_val;
    logic                ping_val;
    logic                hold_val;
    logic                rb_we;
    logic [RADIO_AW-1:0] rb_addr;

    // Result register.
    logic [2:0]          ev_reg;
    logic [7:0]          key_reg;
    logic [RADIO_W-1:0]  radio_reg;
    logic [7:0]          unk_reg;
    logic                link_reg;
    logic                ping_reg;
    logic                hold_reg;

    // Handshake: the result register frees when empty or being taken.
    assign s2_free   = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && s2_free;
    assign in_stall  = s1_valid_reg && !s2_free;
    assign cfg_ready = 1'b1;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= MAX_PINGS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_reg <= cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_func_reg <= func;
            s1_byte_reg <= rx_byte;
        end
    end

    // Decode pass: one word against the current link state.
    always_comb
    begin
        logic [IDX_W-1:0]   wi;
        logic [IDX_W-1:0]   wi_inc;
        logic [7:0]         pc_inc;
        logic [7:0]         view;
        logic               unknown;
        mode_t              mode_w;
        logic [IDX_W-1:0]   idx_w;
        logic [RADIO_W-1:0] acc;

        conn_next = conn_reg;
        mode_next = mode_reg;
        idx_next  = idx_reg;
        pc_next   = pc_reg;
        ev        = EV_NONE;
        key_val   = 8'd0;
        radio_val = '0;
        unk_val   = 8'd0;
        ping_val  = 1'b0;
        hold_val  = 1'b0;
        rb_we     = 1'b0;
        rb_addr   = '0;
        wi        = '0;
        wi_inc    = '0;
        pc_inc    = pc_reg;
        view      = 8'd0;
        unknown   = 1'b0;
        mode_w    = mode_reg;
        idx_w     = idx_reg;
        acc       = '0;

        if (s1_func_reg)
        begin
            // Keepalive tick: always ping, count unanswered pings when up.
            ping_val = 1'b1;
            if (conn_reg)
            begin
                pc_inc  = (pc_reg != PING_MAX) ? pc_reg + 8'd1 : pc_reg;
                pc_next = pc_inc;
                if (pc_inc > max_reg)
                begin
                    conn_next = 1'b0;
                    pc_next   = 8'd0;
                    hold_val  = 1'b1;
                    ev        = EV_DISC;
                end
            end
        end
        else if (!conn_reg)
        begin
            // Link down: the connect byte brings the link up; other bytes only set the mode (V to key, else idle).
            if (s1_byte_reg == BYTE_CONNECT)
            begin
                mode_next = MODE_IDLE;
                idx_next  = '0;
                conn_next = 1'b1;
                pc_next   = 8'd0;
                hold_val  = 1'b1;
                ev        = EV_CONN;
            end
            else if (s1_byte_reg == BYTE_V_UP)
            begin
                mode_next = MODE_KEY;
            end
            else
            begin
                mode_next = MODE_IDLE;
            end
        end
        else if (s1_byte_reg != BYTE_ZERO)
        begin
            // A command letter always starts a new command.
            if (s1_byte_reg == BYTE_V_UP)
            begin
                mode_w = MODE_PONG;
                idx_w  = '0;
            end
            else if (s1_byte_reg == BYTE_K_UP)
            begin
                mode_w = MODE_KEY;
                idx_w  = '0;
            end
            else if (s1_byte_reg == BYTE_R_UP)
            begin
                mode_w = MODE_RADIO;
                idx_w  = '0;
            end
            else if (!(mode_reg inside {MODE_KEY, MODE_RADIO, MODE_PONG}))
            begin
                unknown = 1'b1;
            end

            mode_next = mode_w;
            idx_next  = idx_w;

            if (unknown)
            begin
                mode_next = MODE_IDLE;
                idx_next  = '0;
                ev        = EV_UNKNOWN;
                unk_val   = s1_byte_reg;
            end
            else
            begin
                case (mode_w)
                    MODE_KEY:
                    begin
                        if (idx_w >= IDX_W'(1))
                        begin
                            ev        = EV_KEY;
                            key_val   = s1_byte_reg;
                            mode_next = MODE_IDLE;
                        end
                        else
                        begin
                            idx_next = IDX_W'(1);
                        end
                    end
                    MODE_PONG:
                    begin
                        if (idx_w >= IDX_W'(1))
                        begin
                            if (s1_byte_reg == BYTE_PONG)
                            begin
                                pc_next = 8'd0;
                                ev      = EV_PONG;
                            end
                            mode_next = MODE_IDLE;
                        end
                        else
                        begin
                            idx_next = IDX_W'(1);
                        end
                    end
                    MODE_RADIO:
                    begin
                        // Store the byte and emit the command once full.
                        wi      = (idx_w >= IDX_W'(RADIO_LEN)) ? '0 : idx_w;
                        wi_inc  = wi + IDX_W'(1);
                        rb_we   = 1'b1;
                        rb_addr = wi[RADIO_AW-1:0];
                        if (wi_inc >= IDX_W'(RADIO_LEN))
                        begin
                            for (int k = 0; k < RADIO_LEN; k++)
                            begin
                                view = (RADIO_AW'(k) == rb_addr) ? s1_byte_reg : rb_reg[k];
                                acc  = {acc[RADIO_W-9:0], view};
                            end
                            radio_val = acc;
                            ev        = EV_RADIO;
                            mode_next = MODE_IDLE;
                            idx_next  = '0;
                        end
                        else
                        begin
                            idx_next = wi_inc;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                    end
                endcase
            end
        end
    end

    // Link state registers, updated as the word leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conn_reg <= 1'b0;
            mode_reg <= MODE_IDLE;
            idx_reg  <= '0;
            pc_reg   <= 8'd0;
        end
        else if (s1_adv)
        begin
            conn_reg <= conn_next;
            mode_reg <= mode_next;
            idx_reg  <= idx_next;
            pc_reg   <= pc_next;
        end
    end

    // Radio byte store, written one entry per word in radio mode.
    always_ff @(posedge clk)
    begin
        if (s1_adv && rb_we)
        begin
            rb_reg[rb_addr] <= s1_byte_reg;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            ev_reg    <= ev;
            key_reg   <= key_val;
            radio_reg <= radio_val;
            unk_reg   <= unk_val;
            link_reg  <= conn_next;
            ping_reg  <= ping_val;
            hold_reg  <= hold_val;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_res     = ev_reg;
    assign key_code      = key_reg;
    assign radio_command = radio_reg;
    assign unknown_byte  = unk_reg;
    assign link_up       = link_reg;
    assign send_ping     = ping_reg;
    assign clear_hold    = hold_reg;

    // Checks on the result word.
    `ASSERT_IMPL(a_hold_on_link_change, out_valid_reg,
        hold_reg == (ev_reg == EV_CONN || ev_reg == EV_DISC),
        "clear_hold does not match a link change")
    `ASSERT_IMPL(a_ping_only_on_tick, out_valid_reg && ping_reg,
        ev_reg == EV_NONE || ev_reg == EV_DISC,
        "ping requested alongside a byte event")
    `ASSERT_IMPL(a_link_follows_event, out_valid_reg && (ev_reg == EV_CONN || ev_reg == EV_DISC),
        link_reg == (ev_reg == EV_CONN),
        "link flag disagrees with connect or disconnect event")

endmodule
